### hdl/bcld_pkg.sv
// Shared constants, types and pattern tables of the button command line decoder.
package bcld_pkg;

  localparam int LINE_SIZE   = 64;
  localparam int NUM_BUTTONS = 6;
  localparam int CNT_W       = $clog2(LINE_SIZE);

  localparam int PRESS_LEN   = 6;
  localparam int RELEASE_LEN = 8;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // input kind codes (tuser)
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // event kind codes
  localparam logic EVT_PRESS   = 1'b0;
  localparam logic EVT_RELEASE = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [3:0] button;
    logic       kind;
  } bcld_line_event_t;

  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h42; // B
      2'd1:    c = 8'h54; // T
      2'd2:    c = 8'h4E; // N
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] press_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h5F; // _
      3'd1:    c = 8'h50; // P
      3'd2:    c = 8'h52; // R
      3'd3:    c = 8'h45; // E
      3'd4:    c = 8'h53; // S
      3'd5:    c = 8'h53; // S
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] release_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h5F; // _
      4'd1:    c = 8'h52; // R
      4'd2:    c = 8'h45; // E
      4'd3:    c = 8'h4C; // L
      4'd4:    c = 8'h45; // E
      4'd5:    c = 8'h41; // A
      4'd6:    c = 8'h53; // S
      4'd7:    c = 8'h45; // E
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### hdl/bcld_line_matcher.sv
// Per-line state: prefix check, digit capture and running pattern matchers.
module bcld_line_matcher (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_fire,
  input  logic [7:0]                rx_value,
  output bcld_pkg::bcld_line_event_t line_event
);
  import bcld_pkg::*;

  logic [CNT_W-1:0] char_count, char_count_next;
  logic             string_ended, string_ended_next;
  logic             prefix_good, prefix_good_next;
  logic [7:0]       digit_char, digit_char_next;
  logic [2:0]       press_progress, press_progress_next;
  logic [3:0]       release_progress, release_progress_next;
  logic             press_seen, press_seen_next;
  logic             release_seen, release_seen_next;

  logic       line_end;
  logic [7:0] btn;

  assign line_end = (rx_value == CH_NEWLINE) || (char_count >= CNT_W'(LINE_SIZE - 1));
  assign btn      = digit_char - CH_ZERO;

  always_comb begin
    char_count_next       = char_count;
    string_ended_next     = string_ended;
    prefix_good_next      = prefix_good;
    digit_char_next       = digit_char;
    press_progress_next   = press_progress;
    release_progress_next = release_progress;
    press_seen_next       = press_seen;
    release_seen_next     = release_seen;
    line_event.valid      = 1'b0;
    line_event.button     = btn[3:0];
    line_event.kind       = press_seen ? EVT_PRESS : EVT_RELEASE;

    if (byte_fire) begin
      if (line_end) begin
        line_event.valid = prefix_good && (char_count >= CNT_W'(3)) &&
                           (btn < 8'(NUM_BUTTONS)) && (press_seen || release_seen);
        char_count_next       = '0;
        string_ended_next     = 1'b0;
        prefix_good_next      = 1'b1;
        digit_char_next       = '0;
        press_progress_next   = '0;
        release_progress_next = '0;
        press_seen_next       = 1'b0;
        release_seen_next     = 1'b0;
      end else begin
        char_count_next = char_count + CNT_W'(1);
        if (!string_ended) begin
          if (rx_value == CH_NUL) begin
            string_ended_next = 1'b1;
            if (char_count < CNT_W'(3)) prefix_good_next = 1'b0;
          end else begin
            if (char_count < CNT_W'(3)) begin
              if (rx_value != prefix_char(char_count[1:0])) prefix_good_next = 1'b0;
            end else if (char_count == CNT_W'(3)) begin
              digit_char_next = rx_value;
            end

            if (rx_value == press_char(press_progress)) begin
              if (press_progress == 3'(PRESS_LEN - 1)) begin
                press_seen_next     = 1'b1;
                press_progress_next = '0;
              end else begin
                press_progress_next = press_progress + 3'd1;
              end
            end else begin
              press_progress_next = (rx_value == CH_UNDER) ? 3'd1 : 3'd0;
            end

            if (rx_value == release_char(release_progress)) begin
              if (release_progress == 4'(RELEASE_LEN - 1)) begin
                release_seen_next     = 1'b1;
                release_progress_next = '0;
              end else begin
                release_progress_next = release_progress + 4'd1;
              end
            end else begin
              release_progress_next = (rx_value == CH_UNDER) ? 4'd1 : 4'd0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count       <= '0;
      string_ended     <= 1'b0;
      prefix_good      <= 1'b1;
      digit_char       <= '0;
      press_progress   <= '0;
      release_progress <= '0;
      press_seen       <= 1'b0;
      release_seen     <= 1'b0;
    end else begin
      char_count       <= char_count_next;
      string_ended     <= string_ended_next;
      prefix_good      <= prefix_good_next;
      digit_char       <= digit_char_next;
      press_progress   <= press_progress_next;
      release_progress <= release_progress_next;
      press_seen       <= press_seen_next;
      release_seen     <= release_seen_next;
    end
  end

endmodule

### hdl/bcld_event_reg.sv
// Pending event holder and result register of the read channel.
module bcld_event_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  bcld_pkg::bcld_line_event_t line_event,
  input  logic                      read_fire,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [7:0]                out_data
);
  import bcld_pkg::*;

  logic       event_pending;
  logic [3:0] pending_button;
  logic       pending_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_pending  <= 1'b0;
      pending_button <= '0;
      pending_kind   <= EVT_PRESS;
    end else if (line_event.valid) begin
      event_pending  <= 1'b1;
      pending_button <= line_event.button;
      pending_kind   <= line_event.kind;
    end else if (read_fire) begin
      event_pending  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (read_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // fields of an empty read are zero
  always_ff @(posedge clk) begin
    if (read_fire) begin
      out_data <= {2'b00,
                   event_pending ? pending_kind : 1'b0,
                   event_pending ? pending_button : 4'd0,
                   event_pending};
    end
  end

endmodule

### hdl/button_command_line_decoder_top.sv
// Top level of the button command line decoder.
//
// Slave channel: one transfer per item. tuser selects the kind: 0 carries a
// received byte in tdata[7:0], 1 asks to read and clear the pending event.
// Bytes are gathered into lines ending at newline or when a line is full;
// a line of the form BTN<digit>..._PRESS or ..._RELEASE with a valid digit
// replaces the pending event. Bytes produce no result.
// Master channel: one transfer per read, tdata holds event_ready, the
// button number and press_or_release (0 press, 1 release).
// An item is held in the input register and then decoded; a read result is
// registered in the result register, from which it is offered. Throughput
// is one item per cycle while no read waits on an untaken result, set by the
// single-pass decode between the input and result registers.
// When the receiver stalls, bytes keep flowing until a read reaches the input
// register; a read waits there only while an earlier result is still untaken.
// Reset (rst, synchronous) clears the line state, the pending event and both
// valid flags; there is no clearing pass.
module button_command_line_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] rx_value
  input  logic       s_axis_tuser,  // [0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] event_ready, [4:1] button_number,
                                    // [5] press_or_release, [7:6] zero
);
  import bcld_pkg::*;

  logic       in_valid;
  logic       in_kind;
  logic [7:0] in_value;
  logic       advance;
  logic       byte_fire;
  logic       read_fire;

  bcld_line_event_t line_event;

  assign advance       = in_valid && ((in_kind == KIND_BYTE) || !m_axis_tvalid || m_axis_tready);
  assign byte_fire     = advance && (in_kind == KIND_BYTE);
  assign read_fire     = advance && (in_kind == KIND_READ);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind  <= s_axis_tuser;
      in_value <= s_axis_tdata;
    end
  end

  bcld_line_matcher u_matcher (
    .clk        (clk),
    .rst        (rst),
    .byte_fire  (byte_fire),
    .rx_value   (in_value),
    .line_event (line_event)
  );

  bcld_event_reg u_event (
    .clk        (clk),
    .rst        (rst),
    .line_event (line_event),
    .read_fire  (read_fire),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_data   (m_axis_tdata)
  );

  a_read_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    read_fire |-> (!m_axis_tvalid || m_axis_tready))
    else $error("read decoded over an untaken result");

  a_empty_read_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[7:1] == 7'd0))
    else $error("empty read carries nonzero fields");

  a_held_item_stable: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_value) && $stable(in_kind)))
    else $error("stalled input item changed");

  a_event_only_on_byte: assert property (@(posedge clk) disable iff (rst)
    line_event.valid |-> byte_fire)
    else $error("line event without a byte");

endmodule
